[design/gps_time_source_selector_defines.svh]
// ----------------------------------------------------------------------------
// gps time source selector assertion macros
// checking macros for the selector top-level design file
// ----------------------------------------------------------------------------
`ifndef GPS_TIME_SOURCE_SELECTOR_DEFINES_SVH
`define GPS_TIME_SOURCE_SELECTOR_DEFINES_SVH

// checked only while out of reset
`define GTSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define GTSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[design/gtss_pkg.sv]
// ----------------------------------------------------------------------------
// gtss_pkg
// types and constants of the gps time source selector
// ----------------------------------------------------------------------------
package gtss_pkg;

    // source codes
    localparam logic [1:0] SRC_RTC = 2'd0;
    localparam logic [1:0] SRC_ONE = 2'd1;
    localparam logic [1:0] SRC_TWO = 2'd2;

    // opcodes
    localparam logic [1:0] OP_PULSE_ONE = 2'd0;
    localparam logic [1:0] OP_PULSE_TWO = 2'd1;
    localparam logic [1:0] OP_TICK      = 2'd2;

    // register indexes
    localparam logic [1:0] CFG_STABLE_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_SAVE_PERIOD      = 2'd1;

    localparam logic [7:0] MIN_SATS       = 8'd3;
    localparam logic [7:0] SAVE_WINDOW    = 8'd6;
    localparam logic [7:0] ROLLOVER_GUARD = 8'd56;
    localparam logic [7:0] COUNTDOWN_MIN  = 8'd1;

    localparam logic [7:0] RESET_THRESHOLD = 8'd5;
    localparam logic [7:0] RESET_PERIOD    = 8'd10;

    typedef struct packed {
        logic [1:0] opcode;
        logic       fix_valid_one;
        logic       fix_valid_two;
        logic [7:0] satellites_one;
        logic [7:0] satellites_two;
        logic [6:0] seconds_one;
        logic [6:0] seconds_two;
    } t_item;

    typedef struct packed {
        logic [1:0] source;
        logic       write_rtc;
        logic [6:0] write_seconds;
        logic       status_one;
        logic       status_two;
    } t_result;

    typedef struct packed {
        logic [1:0] source;
        logic [7:0] count_one;
        logic [7:0] count_two;
        logic [7:0] countdown;
    } t_state;

    typedef struct packed {
        logic [7:0] stable_threshold;
        logic [7:0] save_period;
    } t_cfg;

endpackage

[design/gtss_core.sv]
// ----------------------------------------------------------------------------
// gtss_core
// next state and result of one word: pulse counting, rtc write decision,
// save countdown and source selection
// ----------------------------------------------------------------------------
module gtss_core
    import gtss_pkg::*;
(
    input  t_item   i_item,
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    output t_state  o_state,
    output t_result o_result
);

    logic [7:0] sec_plus;
    logic [7:0] cd_tick;
    logic [7:0] cnt1_sat;
    logic [7:0] cnt2_sat;
    logic       stable_one;
    logic       stable_two;
    logic       gps_src;

    assign gps_src    = (i_state.source == SRC_ONE) || (i_state.source == SRC_TWO);
    assign sec_plus   = (i_state.source == SRC_ONE) ? ({1'b0, i_item.seconds_one} + 8'd1)
                                                    : ({1'b0, i_item.seconds_two} + 8'd1);
    assign cd_tick    = (i_state.source != SRC_RTC && i_state.countdown > COUNTDOWN_MIN)
                        ? i_state.countdown - 8'd1 : i_state.countdown;
    assign stable_one = i_state.count_one >= i_cfg.stable_threshold;
    assign stable_two = i_state.count_two >= i_cfg.stable_threshold;
    assign cnt1_sat   = (i_state.count_one > i_cfg.stable_threshold)
                        ? i_cfg.stable_threshold : i_state.count_one;
    assign cnt2_sat   = (i_state.count_two > i_cfg.stable_threshold)
                        ? i_cfg.stable_threshold : i_state.count_two;

    always_comb begin
        o_state                = i_state;
        o_result.write_rtc     = 1'b0;
        o_result.write_seconds = 7'd0;
        case (i_item.opcode)
            OP_PULSE_ONE, OP_PULSE_TWO: begin
                if (i_item.opcode == OP_PULSE_ONE) begin
                    o_state.count_one = i_state.count_one + 8'd1;
                end else begin
                    o_state.count_two = i_state.count_two + 8'd1;
                end
                // no write close to a minute rollover
                if (i_state.countdown < SAVE_WINDOW && gps_src && sec_plus < ROLLOVER_GUARD) begin
                    o_result.write_rtc     = 1'b1;
                    o_result.write_seconds = sec_plus[6:0];
                    o_state.countdown      = i_cfg.save_period;
                end
            end
            OP_TICK: begin
                o_state.countdown = cd_tick;
                if (!i_item.fix_valid_one && !i_item.fix_valid_two
                        && i_state.source != SRC_RTC) begin
                    o_state.source = SRC_RTC;
                end else if (stable_one && i_item.satellites_one >= i_item.satellites_two
                        && i_item.satellites_one > MIN_SATS && i_state.source != SRC_ONE) begin
                    o_state.source = SRC_ONE;
                end else if (stable_two && i_item.satellites_two > i_item.satellites_one
                        && i_item.satellites_two > MIN_SATS && i_state.source != SRC_TWO) begin
                    o_state.source = SRC_TWO;
                end
                o_state.count_one = i_item.fix_valid_one ? cnt1_sat : 8'd0;
                o_state.count_two = i_item.fix_valid_two ? cnt2_sat : 8'd0;
            end
            default: begin
                o_state = i_state;
            end
        endcase
        o_result.source     = o_state.source;
        o_result.status_one = i_item.fix_valid_one;
        o_result.status_two = i_item.fix_valid_two;
    end

endmodule

[design/gps_time_source_selector.sv]
// ----------------------------------------------------------------------------
// gps_time_source_selector
// picks rtc or one of two gps receivers as time source and decides rtc writes
// ----------------------------------------------------------------------------
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_stall    opcode, fix, satellites, seconds
// out       output     o_out_valid / i_out_stall  source, write, seconds, status
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one word per cycle while the output does not stall; each word passes an
// input register, then the selector logic updates the state and loads the
// result register; result valid rises as the word moves into that register
// synchronous active-low reset resets state, threshold to 5, save period to 10
// a stall on the output ripples back to o_in_stall once both registers are full
// ----------------------------------------------------------------------------
`include "gps_time_source_selector_defines.svh"

module gps_time_source_selector
    import gtss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_opcode,
    input  logic       i_fix_valid_one,
    input  logic       i_fix_valid_two,
    input  logic [7:0] i_satellites_one,
    input  logic [7:0] i_satellites_two,
    input  logic [6:0] i_seconds_one,
    input  logic [6:0] i_seconds_two,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_source,
    output logic       o_write_rtc,
    output logic [6:0] o_write_seconds,
    output logic       o_status_one,
    output logic       o_status_two,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic    r_s1_valid;
    t_item   r_s1_item;
    logic    r_out_valid;
    t_result r_out_res;
    t_state  r_state;
    t_cfg    r_cfg;

    t_state  n_state;
    t_result n_res;
    logic    out_load;
    logic    s1_load;

    assign out_load    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_s1_valid && !out_load;
    assign s1_load     = !o_in_stall;
    assign o_cfg_ready = 1'b1;

    gtss_core u_core (
        .i_item   (r_s1_item),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stable_threshold <= RESET_THRESHOLD;
            r_cfg.save_period      <= RESET_PERIOD;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_STABLE_THRESHOLD) begin
                r_cfg.stable_threshold <= i_cfg_data;
            end else if (i_cfg_index == CFG_SAVE_PERIOD) begin
                r_cfg.save_period <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_in_valid) begin
            r_s1_item.opcode         <= i_opcode;
            r_s1_item.fix_valid_one  <= i_fix_valid_one;
            r_s1_item.fix_valid_two  <= i_fix_valid_two;
            r_s1_item.satellites_one <= i_satellites_one;
            r_s1_item.satellites_two <= i_satellites_two;
            r_s1_item.seconds_one    <= i_seconds_one;
            r_s1_item.seconds_two    <= i_seconds_two;
        end
    end

    // state advances exactly when a word moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid       <= 1'b0;
            r_state.source    <= SRC_RTC;
            r_state.count_one <= 8'd0;
            r_state.count_two <= 8'd0;
            r_state.countdown <= RESET_PERIOD;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_out_res <= n_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_source        = r_out_res.source;
    assign o_write_rtc     = r_out_res.write_rtc;
    assign o_write_seconds = r_out_res.write_seconds;
    assign o_status_one    = r_out_res.status_one;
    assign o_status_two    = r_out_res.status_two;

    `GTSS_ASSERT(a_write_guard, o_out_valid && o_write_rtc |-> o_write_seconds != 7'd0 && o_write_seconds < 7'd56, "rtc write near minute rollover")
    `GTSS_ASSERT(a_no_write_zero, o_out_valid && !o_write_rtc |-> o_write_seconds == 7'd0, "seconds set without rtc write")
    `GTSS_ASSERT(a_write_gps_src, o_out_valid && o_write_rtc |-> o_source == SRC_ONE || o_source == SRC_TWO, "rtc write while rtc is source")
    `GTSS_ASSERT(a_state_hold, !(out_load && r_s1_valid) |=> $stable(r_state), "state moved without a word")
    `GTSS_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid && !r_s1_valid, "pipeline not empty after reset")

endmodule

[sim/tb_gps_time_source_selector.sv]
// ----------------------------------------------------------------------------
// tb_gps_time_source_selector
// self-checking bench: directed selection, register extremes and counter
// wrap, then random pulse/tick traffic against a cycle-free predictor, with
// random gaps on the input side and random stalls on the result side
// ----------------------------------------------------------------------------
module tb_gps_time_source_selector;
    import gtss_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;
    localparam int         RUN_LIMIT   = 2_400_000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [1:0] i_opcode = '0;
    logic       i_fix_valid_one = 1'b0;
    logic       i_fix_valid_two = 1'b0;
    logic [7:0] i_satellites_one = '0;
    logic [7:0] i_satellites_two = '0;
    logic [6:0] i_seconds_one = '0;
    logic [6:0] i_seconds_two = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [1:0] o_source;
    logic       o_write_rtc;
    logic [6:0] o_write_seconds;
    logic       o_status_one;
    logic       o_status_two;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;

    // predictor copy of the selector state and registers
    logic [1:0] m_source    = SRC_RTC;
    logic [7:0] m_cnt_one   = '0;
    logic [7:0] m_cnt_two   = '0;
    logic [7:0] m_countdown = RESET_PERIOD;
    logic [7:0] m_threshold = RESET_THRESHOLD;
    logic [7:0] m_period    = RESET_PERIOD;

    t_result predicted_outputs[$];
    bit      idling = 1'b1;
    int      stall_left = 0;
    int      words_sent = 0;
    int      results_checked = 0;
    int      rtc_writes_seen = 0;
    int      mismatches = 0;

    gps_time_source_selector dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #(RUN_LIMIT);
        $display("gps_time_source_selector verification failed");
        $finish;
    end

    // result side back-pressure in random bursts, started only while idling
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left <= int'($urandom_range(0, 2));
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_outputs.size() == 0) begin
                $error("unexpected result word: source %0d write_rtc %0d",
                       o_source, o_write_rtc);
                mismatches++;
            end else begin
                want = predicted_outputs.pop_front();
                results_checked++;
                if (o_write_rtc === 1'b1) rtc_writes_seen++;
                if (o_source !== want.source) begin
                    $error("source: expected %0d, got %0d", want.source, o_source);
                    mismatches++;
                end
                if (o_write_rtc !== want.write_rtc) begin
                    $error("write_rtc: expected %0d, got %0d", want.write_rtc, o_write_rtc);
                    mismatches++;
                end
                if (o_write_seconds !== want.write_seconds) begin
                    $error("write_seconds: expected %0d, got %0d",
                           want.write_seconds, o_write_seconds);
                    mismatches++;
                end
                if (o_status_one !== want.status_one) begin
                    $error("status_one: expected %0d, got %0d", want.status_one, o_status_one);
                    mismatches++;
                end
                if (o_status_two !== want.status_two) begin
                    $error("status_two: expected %0d, got %0d", want.status_two, o_status_two);
                    mismatches++;
                end
            end
        end
    end

    function automatic t_result select_source(input t_item w);
        t_result     r;
        int unsigned secs;
        r = '0;
        r.status_one = w.fix_valid_one;
        r.status_two = w.fix_valid_two;
        case (w.opcode)
            OP_PULSE_ONE, OP_PULSE_TWO: begin
                if (w.opcode == OP_PULSE_ONE) m_cnt_one = m_cnt_one + 8'd1;
                else m_cnt_two = m_cnt_two + 8'd1;
                if (m_countdown < SAVE_WINDOW && (m_source == SRC_ONE || m_source == SRC_TWO)) begin
                    secs = int'(m_source == SRC_ONE ? w.seconds_one : w.seconds_two) + 1;
                    // no write close to a minute rollover
                    if (secs < ROLLOVER_GUARD) begin
                        r.write_rtc = 1'b1;
                        r.write_seconds = secs[6:0];
                        m_countdown = m_period;
                    end
                end
            end
            OP_TICK: begin
                if (m_source != SRC_RTC && m_countdown > COUNTDOWN_MIN)
                    m_countdown = m_countdown - 8'd1;
                if (!w.fix_valid_one && !w.fix_valid_two && m_source != SRC_RTC) begin
                    m_source = SRC_RTC;
                end else if (m_cnt_one >= m_threshold && w.satellites_one >= w.satellites_two &&
                             w.satellites_one > MIN_SATS && m_source != SRC_ONE) begin
                    m_source = SRC_ONE;
                end else if (m_cnt_two >= m_threshold && w.satellites_two > w.satellites_one &&
                             w.satellites_two > MIN_SATS && m_source != SRC_TWO) begin
                    m_source = SRC_TWO;
                end
                if (m_cnt_one > m_threshold) m_cnt_one = m_threshold;
                if (m_cnt_two > m_threshold) m_cnt_two = m_threshold;
                if (!w.fix_valid_one) m_cnt_one = '0;
                if (!w.fix_valid_two) m_cnt_two = '0;
            end
            default: begin
            end
        endcase
        r.source = m_source;
        return r;
    endfunction

    function automatic t_item word(input logic [1:0] op, input logic f1, input logic f2,
                                   input logic [7:0] sat1, input logic [7:0] sat2,
                                   input logic [6:0] sec1, input logic [6:0] sec2);
        t_item w;
        w.opcode = op;
        w.fix_valid_one = f1;
        w.fix_valid_two = f2;
        w.satellites_one = sat1;
        w.satellites_two = sat2;
        w.seconds_one = sec1;
        w.seconds_two = sec2;
        return w;
    endfunction

    // mostly plausible once-a-second traffic, sometimes raw noise
    function automatic t_item random_word(input bit noisy);
        t_item       w;
        logic [63:0] raw;
        int          pick;
        if (noisy) begin
            raw = {$urandom, $urandom};
            w = raw[$bits(t_item)-1:0];
        end else begin
            pick = $urandom_range(0, 99);
            w.opcode = pick < 33 ? OP_PULSE_ONE : pick < 66 ? OP_PULSE_TWO :
                       pick < 98 ? OP_TICK : OP_UNUSED;
            w.fix_valid_one = $urandom_range(0, 9) != 0;
            w.fix_valid_two = $urandom_range(0, 9) != 0;
            w.satellites_one = 8'($urandom_range(0, 12));
            w.satellites_two = 8'($urandom_range(0, 12));
            w.seconds_one = 7'($urandom_range(0, 59));
            w.seconds_two = 7'($urandom_range(0, 59));
        end
        return w;
    endfunction

    task automatic send_word(input t_item w);
        i_in_valid <= 1'b1;
        i_opcode <= w.opcode;
        i_fix_valid_one <= w.fix_valid_one;
        i_fix_valid_two <= w.fix_valid_two;
        i_satellites_one <= w.satellites_one;
        i_satellites_two <= w.satellites_two;
        i_seconds_one <= w.seconds_one;
        i_seconds_two <= w.seconds_two;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted_outputs.push_back(select_source(w));
        words_sent++;
        if (idling && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (predicted_outputs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_STABLE_THRESHOLD: m_threshold = val;
            CFG_SAVE_PERIOD:      m_period = val;
            default: begin
            end
        endcase
    endtask

    task automatic set_config(input logic [7:0] thr, input logic [7:0] per, input bit poke_spare);
        write_reg(CFG_STABLE_THRESHOLD, thr);
        write_reg(CFG_SAVE_PERIOD, per);
        // indexes past the register list must be ignored
        if (poke_spare) begin
            write_reg(CFG_SPARE_A, 8'($urandom));
            write_reg(CFG_SPARE_B, 8'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_selection();
        send_word(word(OP_UNUSED, 1, 1, 8'd255, 8'd255, 7'd127, 7'd127));
        send_word(word(OP_TICK, 0, 0, 8'd0, 8'd0, 7'd0, 7'd0));
        repeat (5) send_word(word(OP_PULSE_ONE, 1, 1, 8'd8, 8'd4, 7'd10, 7'd20));
        send_word(word(OP_TICK, 1, 1, 8'd8, 8'd4, 7'd0, 7'd0));
        // the sender holds off until every result is back
        wait_idle();
        repeat (5) send_word(word(OP_TICK, 1, 1, 8'd8, 8'd4, 7'd0, 7'd0));
        send_word(word(OP_PULSE_ONE, 1, 1, 8'd8, 8'd4, 7'd30, 7'd2));
        send_word(word(OP_PULSE_ONE, 1, 1, 8'd8, 8'd4, 7'd31, 7'd2));
        send_word(word(OP_PULSE_TWO, 1, 1, 8'd8, 8'd4, 7'd5, 7'd40));
        send_word(word(OP_TICK, 1, 1, 8'd4, 8'd9, 7'd0, 7'd0));
        // three satellites is not enough
        send_word(word(OP_TICK, 1, 1, 8'd3, 8'd3, 7'd0, 7'd0));
        send_word(word(OP_TICK, 0, 0, 8'd9, 8'd9, 7'd0, 7'd0));
        send_word(word(OP_TICK, 0, 1, 8'd9, 8'd9, 7'd0, 7'd0));
    endtask

    task automatic test_register_extremes();
        wait_idle();
        set_config(8'd0, 8'd0, 1'b1);
        send_word(word(OP_TICK, 1, 1, 8'd5, 8'd4, 7'd0, 7'd0));
        while (m_countdown >= SAVE_WINDOW)
            send_word(word(OP_TICK, 1, 1, 8'd5, 8'd4, 7'd0, 7'd0));
        send_word(word(OP_PULSE_ONE, 1, 1, 8'd5, 8'd4, 7'd54, 7'd0));
        send_word(word(OP_PULSE_ONE, 1, 1, 8'd5, 8'd4, 7'd55, 7'd0));
        send_word(word(OP_PULSE_ONE, 1, 1, 8'd5, 8'd4, 7'd127, 7'd0));
        send_word(word(OP_PULSE_ONE, 1, 1, 8'd5, 8'd4, 7'd0, 7'd0));
        send_word(word(OP_PULSE_ONE, 1, 1, 8'd5, 8'd4, 7'd99, 7'd0));
        // zero countdown has to stay at zero
        send_word(word(OP_TICK, 1, 1, 8'd5, 8'd4, 7'd0, 7'd0));
        send_word(word(OP_TICK, 1, 1, 8'd4, 8'd9, 7'd0, 7'd0));
        send_word(word(OP_PULSE_TWO, 1, 1, 8'd4, 8'd9, 7'd0, 7'd20));
        // pulse of the other receiver still writes the source's seconds
        send_word(word(OP_PULSE_ONE, 1, 1, 8'd4, 8'd9, 7'd3, 7'd40));
        send_word(word(OP_TICK, 0, 0, 8'd0, 8'd0, 7'd0, 7'd0));
        send_word(word(OP_PULSE_ONE, 1, 1, 8'd0, 8'd0, 7'd10, 7'd10));
    endtask

    task automatic test_threshold_wrap();
        wait_idle();
        set_config(8'd255, 8'd255, 1'b0);
        repeat (255)
            send_word(word(OP_PULSE_ONE, 1, 1, 8'($urandom), 8'($urandom),
                           7'($urandom_range(0, 59)), 7'($urandom_range(0, 59))));
        send_word(word(OP_TICK, 1, 1, 8'd9, 8'd4, 7'd0, 7'd0));
        send_word(word(OP_TICK, 0, 0, 8'd9, 8'd4, 7'd0, 7'd0));
        // 256 pulses bring the count back to zero
        repeat (256)
            send_word(word(OP_PULSE_ONE, 1, 1, 8'($urandom), 8'($urandom),
                           7'($urandom_range(0, 59)), 7'($urandom_range(0, 59))));
        send_word(word(OP_TICK, 1, 1, 8'd9, 8'd4, 7'd0, 7'd0));
    endtask

    task automatic test_random_traffic(input int count, input logic [7:0] thr,
                                       input logic [7:0] per, input bit poke_spare);
        wait_idle();
        set_config(thr, per, poke_spare);
        repeat (count) begin
            send_word(random_word($urandom_range(0, 9) == 0));
            if ($urandom_range(0, 149) == 0) wait_idle();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_selection();
        test_register_extremes();
        test_threshold_wrap();
        test_random_traffic(200, RESET_THRESHOLD, RESET_PERIOD, 1'b0);
        test_random_traffic(150, 8'd0, 8'd0, 1'b1);
        test_random_traffic(200, 8'd2, 8'd3, 1'b0);
        test_random_traffic(150, 8'($urandom_range(1, 8)), 8'($urandom_range(2, 20)), 1'b0);
        wait_idle();
        idling = 1'b0;
        test_random_traffic(200, 8'd4, 8'd6, 1'b0);
        wait_idle();
        $display("covered %0d input words, %0d results checked, %0d rtc writes seen",
                 words_sent, results_checked, rtc_writes_seen);
        $display("thresholds and save periods 0 to 255, counter wrap, spare indexes, opcode 3");
        if (mismatches == 0) begin
            $display("gps_time_source_selector verification clean");
        end else begin
            $display("gps_time_source_selector verification failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/gtss_pkg.sv
design/gtss_core.sv
design/gps_time_source_selector.sv
sim/tb_gps_time_source_selector.sv
